/* hw/rtl/nrdiv_pkg.sv */
// ---------------------------------------------------------------------------
// Non-restoring divider package
// Shared width constant and the per-stage payload carried down the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package nrdiv_pkg;

   localparam int unsigned WIDTH = 32;

   // rem: signed partial remainder, one bit wider than the operands
   // dq:  dividend bits still to shift in (high end), quotient bits (low end)
   typedef struct packed {
      logic [WIDTH:0]   rem;
      logic [WIDTH-1:0] dq;
      logic [WIDTH-1:0] divisor;
      logic             dbz;
   } stage_type;

endpackage

`default_nettype wire

/* hw/rtl/nrdiv_stage.sv */
// ---------------------------------------------------------------------------
// Non-restoring divider stage
// One shift and add/subtract step of the division, registered, with its
// own valid bit and a ready that lets bubbles collapse.
// ---------------------------------------------------------------------------
`default_nettype none

module nrdiv_stage (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  nrdiv_pkg::stage_type in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output nrdiv_pkg::stage_type out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   nrdiv_pkg::stage_type data_ff;
   nrdiv_pkg::stage_type data_in;

   logic [nrdiv_pkg::WIDTH:0] shifted;
   logic [nrdiv_pkg::WIDTH:0] divisor_ext;
   logic [nrdiv_pkg::WIDTH:0] next_rem;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      shifted     = {in_data.rem[nrdiv_pkg::WIDTH-1:0], in_data.dq[nrdiv_pkg::WIDTH-1]};
      divisor_ext = {1'b0, in_data.divisor};
      // subtract on a non-negative remainder, add back on a negative one
      if (in_data.rem[nrdiv_pkg::WIDTH]) begin
         next_rem = shifted + divisor_ext;
      end else begin
         next_rem = shifted - divisor_ext;
      end
      data_in         = in_data;
      data_in.rem     = next_rem;
      data_in.dq      = {in_data.dq[nrdiv_pkg::WIDTH-2:0], ~next_rem[nrdiv_pkg::WIDTH]};
      valid_in        = in_valid || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/nonrestoring_unsigned_divider_unit.sv */
// ---------------------------------------------------------------------------
// Non-restoring unsigned divider unit
// Pipelined 32-bit unsigned division returning quotient and remainder.
// ---------------------------------------------------------------------------
// Takes one dividend/divisor pair per clock unless the pipeline is full and
// the result side stalls. 32 registered stages each perform one shift and
// add/subtract step of non-restoring division, and the output register
// applies the final remainder correction. Every stage has its own valid
// bit, so empty slots are filled while the result side stalls, and the
// unit keeps taking transfers until the pipeline is full. A zero divisor
// returns quotient 0, remainder 0 and the divide-by-zero flag on rsp_tuser.
`default_nettype none

module nonrestoring_unsigned_divider_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [31:0] dividend_in, [63:32] divisor_in
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] quotient_out, [63:32] remainder_out
   output logic        rsp_tuser    // [0] divide_by_zero
);

   localparam int unsigned W = nrdiv_pkg::WIDTH;

   logic                 stg_valid [0:W];
   logic                 stg_ready [0:W];
   nrdiv_pkg::stage_type stg_data  [0:W];

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [W-1:0]    quot_ff;
   logic [W-1:0]    quot_in;
   logic [W-1:0]    rem_ff;
   logic [W-1:0]    rem_in;
   logic            dbz_ff;
   logic            dbz_in;
   logic [W-1:0]    rem_fix;
   logic            out_ready;

   // stage 0 input: clear remainder, load the dividend for shifting
   always_comb begin
      stg_valid[0]         = req_tvalid;
      stg_data[0].rem      = '0;
      stg_data[0].dq       = req_tdata[W-1:0];
      stg_data[0].divisor  = req_tdata[2*W-1:W];
      stg_data[0].dbz      = (req_tdata[2*W-1:W] == '0);
   end
   assign req_tready = stg_ready[0];

   for (genvar i = 0; i < W; i++) begin : g_stage
      nrdiv_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   assign out_ready    = !rsp_valid_ff || rsp_tready;
   assign stg_ready[W] = out_ready;

   always_comb begin
      // add the divisor back if the last partial remainder went negative
      if (stg_data[W].rem[W]) begin
         rem_fix = stg_data[W].rem[W-1:0] + stg_data[W].divisor;
      end else begin
         rem_fix = stg_data[W].rem[W-1:0];
      end
      dbz_in       = stg_data[W].dbz;
      quot_in      = dbz_in ? '0 : stg_data[W].dq;
      rem_in       = dbz_in ? '0 : rem_fix;
      rsp_valid_in = stg_valid[W] || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[W]) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         dbz_ff  <= dbz_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rem_ff, quot_ff};
   assign rsp_tuser  = dbz_ff;

`ifndef ASSERT_OFF
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dbz_ff |-> (quot_ff == '0) && (rem_ff == '0))
      else $error("divide-by-zero result not cleared");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      stg_valid[W] && !stg_data[W].dbz |-> rem_fix < stg_data[W].divisor)
      else $error("corrected remainder not below divisor");

   a_load_flag: assert property (@(posedge clock) disable iff (reset)
      out_ready && stg_valid[W] |=> rsp_valid_ff && (dbz_ff == $past(stg_data[W].dbz)))
      else $error("output register missed a transfer from the last stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      stg_ready[0] |-> !stg_valid[1] || stg_ready[1])
      else $error("input accepted into an occupied stage");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Non-restoring unsigned divider unit testbench
// Drives dividend/divisor pairs into the pipelined divider and checks every
// quotient, remainder and divide-by-zero flag against an in-bench bit-serial
// model. Directed corner operands come first, then random operand mixes with
// random stalls on both sides, then a stretch of back-to-back traffic.
// ---------------------------------------------------------------------------

module tb;

   localparam int W = nrdiv_pkg::WIDTH;
   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] TOP_BIT  = 32'h8000_0000;

   typedef struct packed {
      logic [W-1:0] quot;
      logic [W-1:0] rem;
      logic         dbz;
   } div_result_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [2*W-1:0] req_tdata = '0;   // [31:0] dividend, [63:32] divisor
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [2*W-1:0] rsp_tdata;        // [31:0] quotient, [63:32] remainder
   logic           rsp_tuser;        // [0] divide-by-zero

   div_result_type pending_divs[$];
   int unsigned div_errors   = 0;
   int unsigned results_seen = 0;
   int unsigned dbz_seen     = 0;
   int unsigned pairs_sent   = 0;
   bit          no_stall     = 1'b0;

   nonrestoring_unsigned_divider_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shift in one dividend bit per step; subtract after a non-negative
   // remainder, add after a negative one, then fix up the final remainder.
   function automatic div_result_type nonrestoring_divide(input logic [W-1:0] num,
                                                          input logic [W-1:0] den);
      logic [W:0]     part;
      logic [W-1:0]   q;
      logic           was_neg;
      div_result_type res;
      part = '0;
      q    = '0;
      res  = '0;
      if (den == '0) begin
         res.dbz = 1'b1;
         return res;
      end
      for (int i = W - 1; i >= 0; i--) begin
         was_neg = part[W];
         part = {part[W-1:0], num[i]};
         if (was_neg) begin
            part = part + {1'b0, den};
         end else begin
            part = part - {1'b0, den};
         end
         q = {q[W-2:0], ~part[W]};
      end
      if (part[W]) begin
         part = part + {1'b0, den};
      end
      res.quot = q;
      res.rem  = part[W-1:0];
      return res;
   endfunction

   function automatic bit stall_roll();
      return !no_stall && ($urandom_range(99) < 14);
   endfunction

   function automatic logic [W-1:0] pick_dividend();
      case ($urandom_range(0, 7))
         0: return $urandom >> $urandom_range(0, W - 1);
         1: return ALL_ONES;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [W-1:0] pick_divisor(input logic [W-1:0] num);
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2, 3: return $urandom_range(1, 255);
         4, 5, 6: return $urandom | TOP_BIT;
         7, 8:    return num - $urandom_range(0, 2);
         9:       return num + 1;
         default: return $urandom >> $urandom_range(0, W - 1);
      endcase
   endfunction

   // Hold valid until the transfer, then queue the predicted result.
   task automatic push_division(input logic [W-1:0] num, input logic [W-1:0] den);
      while (stall_roll()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {den, num};
      do @(posedge clock); while (!req_tready);
      pending_divs.push_back(nonrestoring_divide(num, den));
      pairs_sent++;
   endtask

   task automatic test_corner_operands();
      logic [2*W-1:0] pairs[] = '{
         {32'd1, 32'd0},          {32'd1, ALL_ONES},
         {ALL_ONES, ALL_ONES},    {ALL_ONES, 32'd0},
         {ALL_ONES, 32'd1},       {ALL_ONES - 1, ALL_ONES},
         {ALL_ONES, ALL_ONES - 1}, {TOP_BIT, ALL_ONES},
         {TOP_BIT, TOP_BIT},      {TOP_BIT + 1, TOP_BIT},
         {32'd3, TOP_BIT},        {32'd2, ALL_ONES},
         {32'd7, 32'd12345},      {32'd12345, 32'd7},
         {32'd0, 32'd0},          {32'd0, ALL_ONES},
         {32'd0, 32'd1},          {32'd0, 32'h5A5A_A5A5},
         {32'h0001_0000, 32'hFFFF_0000}, {32'hAAAA_AAAA, 32'h5555_5555},
         {32'h5555_5555, 32'hAAAA_AAAA}, {32'h0000_FFFF, ALL_ONES}
      };
      foreach (pairs[k]) begin
         push_division(pairs[k][W-1:0], pairs[k][2*W-1:W]);
      end
   endtask

   task automatic test_random_operands(input int unsigned count);
      logic [W-1:0] num;
      for (int k = 0; k < count; k++) begin
         num = pick_dividend();
         push_division(num, pick_divisor(num));
      end
   endtask

   // Neither side stalls here, so the pipeline runs full.
   task automatic test_back_to_back(input int unsigned count);
      no_stall = 1'b1;
      test_random_operands(count);
      no_stall = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      div_result_type want;
      div_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.quot = rsp_tdata[W-1:0];
         got.rem  = rsp_tdata[2*W-1:W];
         got.dbz  = rsp_tuser;
         results_seen++;
         if (got.dbz) dbz_seen++;
         if (pending_divs.size() == 0) begin
            div_errors++;
            if (div_errors <= 10)
               $display("%0t: result with nothing pending: q=%h r=%h dbz=%b",
                        $realtime, got.quot, got.rem, got.dbz);
         end else begin
            want = pending_divs.pop_front();
            if (got.quot !== want.quot || got.rem !== want.rem || got.dbz !== want.dbz) begin
               div_errors++;
               if (div_errors <= 10)
                  $display("%0t: mismatch: expected q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b",
                           $realtime, want.quot, want.rem, want.dbz,
                           got.quot, got.rem, got.dbz);
            end
         end
      end
      rsp_tready <= !stall_roll();
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_corner_operands();
      test_random_operands(1260);
      test_back_to_back(420);
      req_tvalid <= 1'b0;
      while (pending_divs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d dividend/divisor pairs (corners, random mixes, back-to-back).",
               pairs_sent);
      $display("Checked %0d results, %0d of them divide-by-zero; %0d failures.",
               results_seen, dbz_seen, div_errors);
      if (div_errors == 0) begin
         $display("[nonrestoring_unsigned_divider_unit] OK");
      end else begin
         $display("[nonrestoring_unsigned_divider_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still pending.", pending_divs.size());
      $display("[nonrestoring_unsigned_divider_unit] ERROR");
      $finish;
   end

endmodule
